### src/bblur_pkg.sv
`default_nettype none

package bblur_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int HEIGHT_LIMIT      = 4096;

   // frame width / height / row counter width
   localparam int DIM_W          = 13;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam int CHAN_W   = 8;
   localparam int COLSUM_W = 10;  // three channel values
   localparam int SUM_W    = 12;  // nine channel values

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH  = 4'd0,
      REG_FRAME_HEIGHT = 4'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      DIV_4,
      DIV_6,
      DIV_9
   } divisor_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // one window column: upper row, middle row, incoming row
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
      pixel_type lower;
   } column_type;

   typedef struct packed {
      logic [COLSUM_W-1:0] red;
      logic [COLSUM_W-1:0] green;
      logic [COLSUM_W-1:0] blue;
   } colsum_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } winsum_type;

   typedef struct packed {
      logic shift;
      logic use_upper;
      logic use_lower;
   } cell_ctrl_type;

   function automatic logic [COLSUM_W-1:0] chan_sum(
      input logic [CHAN_W-1:0] upper,
      input logic [CHAN_W-1:0] middle,
      input logic [CHAN_W-1:0] lower,
      input logic              use_upper,
      input logic              use_lower
   );
      logic [COLSUM_W-1:0] up_term;
      logic [COLSUM_W-1:0] lo_term;
      up_term = use_upper ? COLSUM_W'(upper) : '0;
      lo_term = use_lower ? COLSUM_W'(lower) : '0;
      return COLSUM_W'(middle) + up_term + lo_term;
   endfunction

   // masked per-channel sum of one column
   function automatic colsum_type column_sum(
      input column_type col,
      input logic       use_upper,
      input logic       use_lower
   );
      colsum_type s;
      s.red   = chan_sum(col.upper.red, col.middle.red, col.lower.red,
                         use_upper, use_lower);
      s.green = chan_sum(col.upper.green, col.middle.green, col.lower.green,
                         use_upper, use_lower);
      s.blue  = chan_sum(col.upper.blue, col.middle.blue, col.lower.blue,
                         use_upper, use_lower);
      return s;
   endfunction

endpackage

`default_nettype wire

### src/box_blur_3x3_rgb.sv
// Stages: the item that completes a window is registered in the window
//   stage (s1), then in the divide stage, which is the output register.
// Throughput: 1 item per cycle unless the output stalls; the row buffers
//   take one read and one write per cycle; window cells shift once per item.
// Reset: synchronous, active high; sizes return to 2x2, position counters
//   and pipeline valids clear. Row buffers are not cleared.
`default_nettype none

module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH = bblur_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [7:0]                         req_in_red,
   input  logic [7:0]                         req_in_green,
   input  logic [7:0]                         req_in_blue,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_red,
   output logic [7:0]                         rsp_out_green,
   output logic [7:0]                         rsp_out_blue,
   output logic                               rsp_frame_end,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bblur_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bblur_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bblur_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // reciprocals for the constant divides, exact for sums below 2^13
   localparam int           RECIP_SHIFT = 15;
   localparam logic [12:0]  RECIP_6     = 13'd5462;
   localparam logic [12:0]  RECIP_9     = 13'd3641;

   // rounded mean, (sum + n/2) / n with n = 4, 6 or 9
   function automatic logic [CHAN_W-1:0] rounded_mean(
      input logic [SUM_W-1:0] sum,
      input divisor_type      div
   );
      logic [SUM_W:0]       x;
      logic [2*SUM_W+1:0]   prod;
      logic [CHAN_W-1:0]    q;
      x    = '0;
      prod = '0;
      case (div)
         DIV_4: begin
            x = {1'b0, sum} + (SUM_W+1)'(2);
            q = x[CHAN_W+1:2];
         end
         DIV_6: begin
            x    = {1'b0, sum} + (SUM_W+1)'(3);
            prod = x * RECIP_6;
            q    = prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
         end
         DIV_9: begin
            x    = {1'b0, sum} + (SUM_W+1)'(4);
            prod = x * RECIP_9;
            q    = prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
         end
         default: begin
            q = '0;
         end
      endcase
      return q;
   endfunction

   // ---------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------
   logic [DIM_W-1:0] width_ff,  width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             csr_fire;
   logic             csr_hit;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   // only a write to a real register aborts the frame
   assign csr_hit   = csr_fire && (csr_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT});

   // out-of-range sizes are clamped when written
   always_comb begin
      logic [DIM_W-1:0] wv;
      logic [DIM_W-1:0] hv;
      wv        = DIM_W'(csr_data[FRAME_WIDTH_W-1:0]);
      hv        = csr_data[FRAME_HEIGHT_W-1:0];
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_fire) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               if (wv < DIM_W'(2))              width_in = DIM_W'(2);
               else if (wv > DIM_W'(MAX_WIDTH)) width_in = DIM_W'(MAX_WIDTH);
               else                             width_in = wv;
            end
            REG_FRAME_HEIGHT: begin
               if (hv < DIM_W'(2))                 height_in = DIM_W'(2);
               else if (hv > DIM_W'(HEIGHT_LIMIT)) height_in = DIM_W'(HEIGHT_LIMIT);
               else                                height_in = hv;
            end
            default: begin
               // unknown register: no effect
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(2);
         height_ff <= DIM_W'(2);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------------------------------------------------------
   // handshake: window stage (s1) feeds the output register
   // ---------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff;
   logic s2_load;
   logic s1_free;
   logic req_fire;

   assign s2_load   = !rsp_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || s2_load;
   assign req_ready = s1_free;
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------
   // input position and border decode
   // ---------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] col_ext;
   logic [DIM_W-1:0] col_inc;
   logic             col_zero;
   logic             drain;
   logic             skip;
   logic             advance;
   logic             have;
   logic             emit;
   logic             use_upper;
   logic             use_lower;
   logic             use_left;
   logic             use_right;
   logic             frame_end;

   assign col_ext  = DIM_W'(col_ff);
   assign col_inc  = col_ext + DIM_W'(1);
   assign col_zero = (col_ff == '0);

   // after the last pixel row every item is a drain item
   assign drain   = (row_ff >= height_ff);
   // a drain item that comes too early is swallowed
   assign skip    = !drain && req_action;
   assign advance = req_fire && !skip;

   // Output center is one row and one pixel behind the input; at column 0
   // it is the last pixel of the row two back.
   assign have      = col_zero ? (row_ff >= DIM_W'(2)) : (row_ff != '0);
   assign use_upper = col_zero ? (row_ff >= DIM_W'(3)) : (row_ff >= DIM_W'(2));
   assign use_lower = col_zero ? (row_ff <= height_ff) : (row_ff < height_ff);
   assign use_left  = col_zero || (col_ext >= DIM_W'(2));
   assign use_right = !col_zero;
   assign frame_end = col_zero && (row_ff == height_ff + DIM_W'(1));
   assign emit      = advance && have;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (emit && frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= width_ff) begin
            col_in = '0;
            row_in = row_ff + DIM_W'(1);
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------
   // row buffers
   // ---------------------------------------------------------------
   pixel_type  pix;
   pixel_type  lb_upper;
   pixel_type  lb_middle;
   column_type new_col;

   assign pix.red   = drain ? '0 : req_in_red;
   assign pix.green = drain ? '0 : req_in_green;
   assign pix.blue  = drain ? '0 : req_in_blue;

   // read address is the next column, so data is ready for the next item
   bblur_linebuf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_linebuf (
      .clock     (clock),
      .rd_addr   (col_in),
      .wr_en     (advance && !drain),
      .wr_addr   (col_ff),
      .wr_data   (pix),
      .rd_upper  (lb_upper),
      .rd_middle (lb_middle)
   );

   assign new_col.upper  = lb_upper;
   assign new_col.middle = lb_middle;
   assign new_col.lower  = pix;

   // ---------------------------------------------------------------
   // window: two column cells; the incoming column is the third
   // ---------------------------------------------------------------
   cell_ctrl_type cell_ctrl;
   column_type    center_col;
   colsum_type    left_sum;
   colsum_type    center_sum;
   colsum_type    right_sum;

   assign cell_ctrl.shift     = advance;
   assign cell_ctrl.use_upper = use_upper;
   assign cell_ctrl.use_lower = use_lower;

   bblur_cell u_cell_center (
      .clock   (clock),
      .ctrl    (cell_ctrl),
      .col_in  (new_col),
      .col_out (center_col),
      .col_sum (center_sum)
   );

   bblur_cell u_cell_left (
      .clock   (clock),
      .ctrl    (cell_ctrl),
      .col_in  (center_col),
      .col_out (),
      .col_sum (left_sum)
   );

   assign right_sum = column_sum(new_col, use_upper, use_lower);

   winsum_type  win_sum;
   divisor_type win_div;

   always_comb begin
      win_sum.red   = SUM_W'(center_sum.red)
                    + (use_left  ? SUM_W'(left_sum.red)  : '0)
                    + (use_right ? SUM_W'(right_sum.red) : '0);
      win_sum.green = SUM_W'(center_sum.green)
                    + (use_left  ? SUM_W'(left_sum.green)  : '0)
                    + (use_right ? SUM_W'(right_sum.green) : '0);
      win_sum.blue  = SUM_W'(center_sum.blue)
                    + (use_left  ? SUM_W'(left_sum.blue)  : '0)
                    + (use_right ? SUM_W'(right_sum.blue) : '0);
      // 3x3 inside, 2x3 / 3x2 on an edge, 2x2 at a corner
      if ((use_upper && use_lower) && (use_left && use_right)) begin
         win_div = DIV_9;
      end else if ((use_upper && use_lower) || (use_left && use_right)) begin
         win_div = DIV_6;
      end else begin
         win_div = DIV_4;
      end
   end

   // ---------------------------------------------------------------
   // s1: registered window sums
   // ---------------------------------------------------------------
   winsum_type  s1_sum_ff;
   divisor_type s1_div_ff;
   logic        s1_end_ff;

   assign s1_valid_in = s1_free ? emit : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_sum_ff <= win_sum;
         s1_div_ff <= win_div;
         s1_end_ff <= frame_end;
      end
   end

   // ---------------------------------------------------------------
   // output register: constant divide
   // ---------------------------------------------------------------
   pixel_type rsp_pix_ff;
   logic      rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         rsp_pix_ff.red   <= rounded_mean(s1_sum_ff.red,   s1_div_ff);
         rsp_pix_ff.green <= rounded_mean(s1_sum_ff.green, s1_div_ff);
         rsp_pix_ff.blue  <= rounded_mean(s1_sum_ff.blue,  s1_div_ff);
         rsp_end_ff       <= s1_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff.red;
   assign rsp_out_green = rsp_pix_ff.green;
   assign rsp_out_blue  = rsp_pix_ff.blue;
   assign rsp_frame_end = rsp_end_ff;

`ifndef SYNTHESIS
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ext < width_ff)
      else $error("input column beyond frame width");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_ff + DIM_W'(1))
      else $error("input row beyond drain rows");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (emit && frame_end) |=> (col_ff == '0 && row_ff == '0))
      else $error("position not cleared after frame end");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> (s1_valid_ff && $stable(s1_sum_ff)))
      else $error("window stage lost an item while stalled");
`endif

endmodule

`default_nettype wire

### src/bblur_cell.sv
`default_nettype none

module bblur_cell (
   input  logic                      clock,
   input  bblur_pkg::cell_ctrl_type  ctrl,
   input  bblur_pkg::column_type     col_in,
   output bblur_pkg::column_type     col_out,
   output bblur_pkg::colsum_type     col_sum
);
   import bblur_pkg::*;

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;
   assign col_sum = column_sum(col_ff, ctrl.use_upper, ctrl.use_lower);

endmodule

`default_nettype wire

### src/bblur_linebuf.sv
`default_nettype none

module bblur_linebuf #(
   parameter  int MAX_WIDTH = bblur_pkg::DEFAULT_MAX_WIDTH,
   localparam int ADDR_W    = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic [ADDR_W-1:0]     rd_addr,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  bblur_pkg::pixel_type  wr_data,
   output bblur_pkg::pixel_type  rd_upper,
   output bblur_pkg::pixel_type  rd_middle
);
   import bblur_pkg::*;

   pixel_type upper_row_ff  [MAX_WIDTH];
   pixel_type middle_row_ff [MAX_WIDTH];
   pixel_type rd_upper_ff;
   pixel_type rd_middle_ff;

   // rd_addr runs one item ahead, so the registered read of wr_addr is
   // on hand when the write happens: upper takes the old middle entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_row_ff[wr_addr]  <= rd_middle_ff;
         middle_row_ff[wr_addr] <= wr_data;
      end
      rd_upper_ff  <= upper_row_ff[rd_addr];
      rd_middle_ff <= middle_row_ff[rd_addr];
   end

   assign rd_upper  = rd_upper_ff;
   assign rd_middle = rd_middle_ff;

endmodule

`default_nettype wire

### tb/bblur_tb_pkg.sv
`timescale 1ns / 100ps

package bblur_tb_pkg;

   // meaning of req_action
   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_DRAIN = 1'b1
   } action_type;

endpackage

### tb/box_blur_3x3_rgb_checker.sv
`timescale 1ns / 100ps

module box_blur_3x3_rgb_checker
   import bblur_pkg::*;
   import bblur_tb_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_action,
   input  logic [7:0]             req_in_red,
   input  logic [7:0]             req_in_green,
   input  logic [7:0]             req_in_blue,

   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [7:0]             rsp_out_red,
   input  logic [7:0]             rsp_out_green,
   input  logic [7:0]             rsp_out_blue,
   input  logic                   rsp_frame_end,

   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,

   output int unsigned            mismatch_count,
   output int unsigned            results_due
);

   typedef struct packed {
      pixel_type mean;
      logic      frame_end;
   } blurred_type;

   logic [FRAME_WIDTH_W-1:0]  width_reg;
   logic [FRAME_HEIGHT_W-1:0] height_reg;
   pixel_type                 upper_row  [MAX_WIDTH];
   pixel_type                 middle_row [MAX_WIDTH];
   pixel_type                 window     [9];
   int unsigned               in_col;
   int unsigned               in_row;
   blurred_type               blurred_q  [$];

   function automatic int unsigned chan_of(input pixel_type p, input int unsigned k);
      case (k)
         0:       return p.red;
         1:       return p.green;
         default: return p.blue;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // one accepted item: update rows, window and position, queue the blurred pixel
   task automatic take_item(input logic action, input pixel_type px);
      int unsigned w, h, c, r, idx, cc, cr, rows, cols, n, s, k, y;
      bit          drain, have, top, bot, left, right;
      pixel_type   column [3];
      logic [7:0]  mean   [3];
      blurred_type res;

      w = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg < 2) ? 2 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
      drain = in_row >= h;
      if (!drain && action == ACT_DRAIN)
         return;  // early drain: ignored

      c = in_col;
      r = in_row;
      idx = c % MAX_WIDTH;
      column[0] = upper_row[idx];
      column[1] = middle_row[idx];
      column[2] = drain ? pixel_type'(0) : px;
      if (!drain) begin
         upper_row[idx] = middle_row[idx];
         middle_row[idx] = px;
      end

      // output center trails the input by one row and one pixel
      cr = 0;
      if (c >= 1) begin
         have = r >= 1;
         if (have) cr = r - 1;
         cc = c - 1;
      end else begin
         have = r >= 2;
         if (have) cr = r - 2;
         cc = w - 1;
      end

      if (have) begin
         top = cr >= 1;
         bot = cr + 2 <= h;
         left = cc >= 1;
         right = c != 0;
         rows = 1 + (top ? 1 : 0) + (bot ? 1 : 0);
         cols = 1 + (left ? 1 : 0) + (right ? 1 : 0);
         n = rows * cols;
         for (k = 0; k < 3; k++) begin
            s = 0;
            for (y = 0; y < 3; y++) begin
               if ((y == 0 && !top) || (y == 2 && !bot)) continue;
               if (left) s += chan_of(window[y * 3 + 1], k);
               s += chan_of(window[y * 3 + 2], k);
               if (right) s += chan_of(column[y], k);
            end
            mean[k] = 8'((s + n / 2) / n);
         end
         res.mean.red = mean[0];
         res.mean.green = mean[1];
         res.mean.blue = mean[2];
         res.frame_end = (cr == h - 1) && (cc == w - 1);
         blurred_q.push_back(res);
      end

      for (y = 0; y < 3; y++) begin
         window[y * 3] = window[y * 3 + 1];
         window[y * 3 + 1] = window[y * 3 + 2];
         window[y * 3 + 2] = column[y];
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      in_col = c & 'h3FF;
      in_row = r & 'h1FFF;
      if (have && res.frame_end) begin
         in_col = 0;
         in_row = 0;
      end
   endtask

   task automatic check_result();
      blurred_type want;
      if (blurred_q.size() == 0) begin
         $error("result with nothing due: red %0d green %0d blue %0d frame_end %0b",
                rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end);
         mismatch_count++;
         return;
      end
      want = blurred_q.pop_front();
      compare_field("out_red", want.mean.red, rsp_out_red);
      compare_field("out_green", want.mean.green, rsp_out_green);
      compare_field("out_blue", want.mean.blue, rsp_out_blue);
      compare_field("frame_end", 8'(want.frame_end), 8'(rsp_frame_end));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = 2;
         height_reg = 2;
         in_col = 0;
         in_row = 0;
         mismatch_count = 0;
         foreach (window[i]) window[i] = '0;
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         blurred_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            // a write to a real register aborts the frame
            case (csr_index)
               REG_FRAME_WIDTH: begin
                  width_reg = csr_data[FRAME_WIDTH_W-1:0];
                  in_col = 0;
                  in_row = 0;
               end
               REG_FRAME_HEIGHT: begin
                  height_reg = csr_data[FRAME_HEIGHT_W-1:0];
                  in_col = 0;
                  in_row = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            take_item(req_action, pixel_type'({req_in_red, req_in_green, req_in_blue}));
         if (rsp_valid && rsp_ready)
            check_result();
      end
      results_due = blurred_q.size();
   end

endmodule

### tb/box_blur_3x3_rgb_test.sv
`timescale 1ns / 100ps

module box_blur_3x3_rgb_test;

   import bblur_pkg::*;
   import bblur_tb_pkg::*;

   // random part stops once this many counted items went in
   localparam int unsigned RANDOM_ITEMS = 600;
   // cycles to let the two pipeline stages empty before a register write
   localparam int unsigned HOLD_OFF = 8;
   // cycles without any handshake before the run is declared hung
   localparam int unsigned IDLE_LIMIT = 2000;

   // 3x3 directed frame, red channel in raster order; chosen so the corner and
   // edge windows clear of the 255 land exactly on a half and must round up
   localparam logic [71:0] RED_3X3 = {8'd1, 8'd1, 8'd0,
                                      8'd0, 8'd0, 8'd1,
                                      8'd255, 8'd0, 8'd1};

   logic                   clock;
   logic                   reset;

   logic                   req_valid;
   logic                   req_ready;
   logic                   req_action;
   logic [7:0]             req_in_red;
   logic [7:0]             req_in_green;
   logic [7:0]             req_in_blue;

   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_out_red;
   logic [7:0]             rsp_out_green;
   logic [7:0]             rsp_out_blue;
   logic                   rsp_frame_end;

   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int unsigned            mismatch_count;
   int unsigned            results_due;

   // effective frame size as the block sees it after clamping
   int unsigned            frame_w;
   int unsigned            frame_h;
   // counted items sent (ignored early drains are not counted)
   int unsigned            items_sent;
   // when set, neither side inserts idle cycles
   bit                     steady;
   int unsigned            idle_cycles = 0;

   box_blur_3x3_rgb u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   box_blur_3x3_rgb_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_end  (rsp_frame_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Hang detection: any handshake on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("box_blur_3x3_rgb test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: before each item, drop ready at random (never in steady
   // phases), then hold ready until a result is taken.
   initial begin
      int unsigned gap;
      rsp_ready = 1'b0;
      @(negedge clock iff (reset == 1'b0));
      forever begin
         gap = steady ? 0 : $urandom_range(0, 17);
         if (gap != 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock iff (rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   function automatic logic [7:0] random_level();
      // extremes often, so full-scale sums and zero sums both show up
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.red = random_level();
      px.green = random_level();
      px.blue = random_level();
      return px;
   endfunction

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      return (v < 2) ? 2 : ((v > hi) ? hi : v);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so back-to-back items need no gap. Anything that
   // pauses the sender must drop valid first.
   task automatic send_item(input action_type action, input pixel_type px,
                            input bit counted);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = action;
      req_in_red = px.red;
      req_in_green = px.green;
      req_in_blue = px.blue;
      @(posedge clock iff req_ready);
      @(negedge clock);
      if (counted) items_sent++;
   endtask

   // Sender pause: every due result out, then let the pipeline settle.
   task automatic wait_for_results();
      req_valid = 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = data;
      @(posedge clock iff csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Unused register index: the write must leave size and position alone.
   task automatic write_unused();
      write_reg(CSR_INDEX_W'($urandom_range(REG_FRAME_HEIGHT + 1, 2 ** CSR_INDEX_W - 1)),
                CSR_DATA_W'($urandom()));
   endtask

   // New frame size. Upper data bits above the register width are random
   // and must be dropped by the block.
   task automatic set_size(input int unsigned raw_w, input int unsigned raw_h);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] hdata;
      wait_for_results();
      wdata = CSR_DATA_W'($urandom());
      wdata[FRAME_WIDTH_W-1:0] = raw_w[FRAME_WIDTH_W-1:0];
      hdata = CSR_DATA_W'($urandom());
      hdata[FRAME_HEIGHT_W-1:0] = raw_h[FRAME_HEIGHT_W-1:0];
      if ($urandom_range(0, 1) == 0) begin
         write_reg(REG_FRAME_WIDTH, wdata);
         write_reg(REG_FRAME_HEIGHT, hdata);
      end else begin
         write_reg(REG_FRAME_HEIGHT, hdata);
         write_reg(REG_FRAME_WIDTH, wdata);
      end
      if ($urandom_range(0, 3) == 0) write_unused();
      frame_w = clamp_dim(wdata[FRAME_WIDTH_W-1:0], DEFAULT_MAX_WIDTH);
      frame_h = clamp_dim(hdata[FRAME_HEIGHT_W-1:0], HEIGHT_LIMIT);
      steady = ($urandom_range(0, 3) == 0);
   endtask

   // One frame of random pixels at the current size. If stop_at is short
   // of the pixel count the frame is left unfinished (the next size write
   // aborts it); otherwise width+1 drain items flush the last row.
   task automatic run_frame(input int unsigned stop_at);
      int unsigned total;
      int unsigned k;
      total = frame_w * frame_h;
      for (k = 0; k < total && k < stop_at; k++) begin
         // drain item while pixels are still due: must be ignored
         if ($urandom_range(0, 15) == 0) send_item(ACT_DRAIN, random_pixel(), 1'b0);
         // sender holds off until every result is out
         if ($urandom_range(0, 63) == 0) wait_for_results();
         // idle mid-frame write to an unused index
         if ($urandom_range(0, 199) == 0) begin
            wait_for_results();
            write_unused();
         end
         send_item(ACT_PIXEL, random_pixel(), 1'b1);
      end
      if (stop_at >= total) begin
         // a pixel while drains are due counts as a drain
         for (k = 0; k <= frame_w; k++)
            send_item(($urandom_range(0, 4) == 0) ? ACT_PIXEL : ACT_DRAIN,
                      random_pixel(), 1'b1);
      end
   endtask

   initial begin
      int unsigned raw_w, raw_h, frames, f, stop_at, k;
      pixel_type   px;

      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_PIXEL;
      req_in_red = '0;
      req_in_green = '0;
      req_in_blue = '0;
      csr_valid = 1'b0;
      csr_index = REG_FRAME_WIDTH;
      csr_data = '0;
      steady = 1'b0;
      frame_w = 2;
      frame_h = 2;
      items_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed: 2x2 frame at the reset size, every window a corner ----
      send_item(ACT_DRAIN, pixel_type'({8'hFF, 8'hFF, 8'hFF}), 1'b0);  // too early
      send_item(ACT_PIXEL, pixel_type'({8'hFF, 8'h00, 8'hFF}), 1'b1);
      send_item(ACT_PIXEL, pixel_type'({8'h00, 8'hFF, 8'h01}), 1'b1);
      send_item(ACT_PIXEL, pixel_type'({8'hFF, 8'hFF, 8'hFF}), 1'b1);
      send_item(ACT_PIXEL, pixel_type'({8'h00, 8'h00, 8'hFE}), 1'b1);
      send_item(ACT_DRAIN, pixel_type'({8'h00, 8'h00, 8'h00}), 1'b1);
      send_item(ACT_PIXEL, pixel_type'({8'hAA, 8'h55, 8'hAA}), 1'b1);  // acts as drain
      send_item(ACT_DRAIN, pixel_type'({8'h00, 8'h00, 8'h00}), 1'b1);

      // ---- directed: 3x3 frame, corners, edges and the one full window ----
      // green at full scale everywhere (largest sums), blue a walking bit so
      // any channel mix-up shows
      set_size(3, 3);
      steady = 1'b0;
      for (k = 0; k < 9; k++) begin
         px.red = RED_3X3[8 * (8 - k) +: 8];
         px.green = 8'hFF;
         px.blue = (k == 8) ? 8'hFE : 8'(1 << k);
         send_item(ACT_PIXEL, px, 1'b1);
      end
      for (k = 0; k < 4; k++)
         send_item(ACT_DRAIN, pixel_type'(0), 1'b1);

      // ---- random: mostly small frames, some clamped sizes, some aborts ----
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0:       raw_w = $urandom_range(0, 1);
            1:       raw_w = $urandom_range(10, 40);
            default: raw_w = $urandom_range(2, 9);
         endcase
         case ($urandom_range(0, 7))
            0:       raw_h = $urandom_range(0, 1);
            1:       raw_h = $urandom_range(7, 16);
            default: raw_h = $urandom_range(2, 6);
         endcase
         set_size(raw_w, raw_h);
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            stop_at = frame_w * frame_h;
            // only the last frame of a phase may be cut off
            if (f == frames - 1 && $urandom_range(0, 4) == 0)
               stop_at = $urandom_range(1, frame_w * frame_h - 1);
            run_frame(stop_at);
         end
      end

      wait_for_results();
      if (mismatch_count == 0 && results_due == 0) begin
         $display("box_blur_3x3_rgb test passed");
      end else begin
         $display("box_blur_3x3_rgb test failed");
      end
      $finish;
   end

endmodule
